FILE: rtl/core/pfa_pkg.sv
package pfa_pkg;

	localparam int ADDR_WIDTH       = 32;
	localparam int PAGE_SHIFT       = 12;
	localparam int FRAME_IN_WIDTH   = ADDR_WIDTH - PAGE_SHIFT;
	localparam int KIND_WIDTH       = 2;
	localparam int STATUS_WIDTH     = 3;
	localparam int FRAME_ADDR_WIDTH = 27;
	localparam int OUT_COUNT_WIDTH  = 16;
	localparam int LFF_WIDTH        = 15;

	localparam int DEF_NUM_FRAMES      = 32768;
	localparam int DEF_RESERVED_FRAMES = 64;
	localparam int DEF_COUNT_WIDTH     = 16;

	typedef enum logic [KIND_WIDTH-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_INC   = 2'd2,
		KIND_DEC   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BADADDR  = 3'd2,
		ST_ZERO     = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

FILE: rtl/core/pfa_if.sv
interface pfa_req_if;
	logic                               valid;
	logic                               ready;
	logic [pfa_pkg::KIND_WIDTH-1:0]     kind;
	logic [pfa_pkg::ADDR_WIDTH-1:0]     page_address;

	modport source (output valid, kind, page_address, input ready);
	modport sink (input valid, kind, page_address, output ready);
endinterface

interface pfa_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic [pfa_pkg::STATUS_WIDTH-1:0]     status;
	logic [pfa_pkg::FRAME_ADDR_WIDTH-1:0] frame_address;
	logic [pfa_pkg::OUT_COUNT_WIDTH-1:0]  new_count;
	logic                                 frame_released;

	modport source (output valid, status, frame_address, new_count, frame_released, input ready);
	modport sink (input valid, status, frame_address, new_count, frame_released, output ready);
endinterface

FILE: rtl/core/pfa_ram.sv
module pfa_ram #(
	parameter int DEPTH = 32768,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/page_frame_allocator_refcount.sv
// Page frame allocator with reference counts. After reset the block runs a clearing pass over
// all NUM_FRAMES entries that loads the reference count memory (1 for reserved frames, 0
// otherwise); no request is taken during it, although configuration writes are. Requests are
// then handled one at a time: a synchronous read of the count memory and the free-stack memory
// when the request is taken, then the update and write-back, which also loads the response
// register. A request may be taken while the previous response still waits, but the update
// stage holds until that response has been taken.
module page_frame_allocator_refcount #(
	parameter int NUM_FRAMES      = pfa_pkg::DEF_NUM_FRAMES,
	parameter int RESERVED_FRAMES = pfa_pkg::DEF_RESERVED_FRAMES,
	parameter int COUNT_WIDTH     = pfa_pkg::DEF_COUNT_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pfa_req_if.sink                       req,
	pfa_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [pfa_pkg::LFF_WIDTH-1:0] cfg_wdata
);

	import pfa_pkg::*;

	localparam int FW        = $clog2(NUM_FRAMES);
	localparam int CW        = $clog2(NUM_FRAMES + 1);
	localparam int INIT_FREE = (NUM_FRAMES > RESERVED_FRAMES) ? NUM_FRAMES - RESERVED_FRAMES : 0;

	state_t state_q, state_d;

	logic [LFF_WIDTH-1:0]      lowest_q;
	logic [CW-1:0]             fc_q, fc_d;
	logic [CW-1:0]             lw_q, lw_d;
	logic [FW-1:0]             clr_q;

	kind_t                     kind_s1;
	logic [FRAME_IN_WIDTH-1:0] frame_s1;
	logic                      misal_s1;
	logic                      in_range_s1;
	logic                      below_s1;
	logic [FW-1:0]             pos_s1;
	logic                      pop_init_s1;

	logic                      out_valid_q;
	status_t                   status_q;
	logic [FRAME_ADDR_WIDTH-1:0] faddr_q;
	logic [OUT_COUNT_WIDTH-1:0]  ncnt_q;
	logic                      rel_q;

	logic                      accept;
	logic                      exec_fire;
	logic [FRAME_IN_WIDTH-1:0] in_frame;
	logic [CW-1:0]             pop_pos;

	logic                      ref_we, ex_ref_we;
	logic [FW-1:0]             ref_wa, ex_ref_wa;
	logic [COUNT_WIDTH-1:0]    ref_wd, ex_ref_wd;
	logic [COUNT_WIDTH-1:0]    cnt_rd;
	logic                      stk_we;
	logic [FW-1:0]             stk_wa;
	logic [FW-1:0]             stk_wd;
	logic [FW-1:0]             stk_rd;
	logic [FW-1:0]             pop_frame;

	status_t                     st_d;
	logic [FRAME_ADDR_WIDTH-1:0] faddr_d;
	logic [OUT_COUNT_WIDTH-1:0]  ncnt_d;
	logic                        rel_d;

	assign accept    = req.valid && req.ready;
	assign exec_fire = (state_q == S_EXEC) && (!out_valid_q || rsp.ready);
	assign in_frame  = req.page_address[ADDR_WIDTH-1:PAGE_SHIFT];
	assign pop_pos   = fc_q - CW'(1);

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.frame_address  = faddr_q;
	assign rsp.new_count      = ncnt_q;
	assign rsp.frame_released = rel_q;

	pfa_ram #(.DEPTH(NUM_FRAMES), .WIDTH(COUNT_WIDTH)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_wa),
		.wdata (ref_wd),
		.re    (accept),
		.raddr (in_frame[FW-1:0]),
		.rdata (cnt_rd)
	);

	pfa_ram #(.DEPTH(NUM_FRAMES), .WIDTH(FW)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_wa),
		.wdata (stk_wd),
		.re    (accept),
		.raddr (pop_pos[FW-1:0]),
		.rdata (stk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == FW'(NUM_FRAMES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (exec_fire) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Stack slots below the lowest fill level ever reached were never written, so are computed.
	assign pop_frame = pop_init_s1 ? FW'(32'(pos_s1) + 32'(RESERVED_FRAMES)) : stk_rd;

	always_comb begin
		st_d      = ST_OK;
		faddr_d   = '0;
		ncnt_d    = '0;
		rel_d     = 1'b0;
		ex_ref_we = 1'b0;
		ex_ref_wa = frame_s1[FW-1:0];
		ex_ref_wd = cnt_rd;
		stk_we    = 1'b0;
		stk_wa    = fc_q[FW-1:0];
		stk_wd    = frame_s1[FW-1:0];
		fc_d      = fc_q;
		lw_d      = lw_q;
		case (kind_s1)
			KIND_ALLOC: begin
				if (fc_q == CW'(0)) begin
					st_d = ST_EMPTY;
				end else begin
					fc_d = pop_pos;
					if (pop_pos < lw_q) begin
						lw_d = pop_pos;
					end
					ex_ref_we = 1'b1;
					ex_ref_wa = pop_frame;
					ex_ref_wd = COUNT_WIDTH'(1);
					faddr_d   = FRAME_ADDR_WIDTH'({pop_frame, PAGE_SHIFT'(0)});
					ncnt_d    = OUT_COUNT_WIDTH'(1);
				end
			end
			default: begin
				if (!in_range_s1) begin
					st_d = ST_BADADDR;
				end else if (kind_s1 == KIND_INC) begin
					if (cnt_rd == '1) begin
						st_d   = ST_OVERFLOW;
						ncnt_d = OUT_COUNT_WIDTH'(cnt_rd);
					end else begin
						ex_ref_we = 1'b1;
						ex_ref_wd = cnt_rd + COUNT_WIDTH'(1);
						ncnt_d    = OUT_COUNT_WIDTH'(cnt_rd + COUNT_WIDTH'(1));
					end
				end else if (kind_s1 == KIND_FREE && (misal_s1 || below_s1)) begin
					st_d = ST_BADADDR;
				end else if (cnt_rd == '0) begin
					st_d = ST_ZERO;
				end else begin
					ex_ref_we = 1'b1;
					ex_ref_wd = cnt_rd - COUNT_WIDTH'(1);
					if (kind_s1 == KIND_FREE && cnt_rd == COUNT_WIDTH'(1)
					    && fc_q < CW'(NUM_FRAMES)) begin
						stk_we = 1'b1;
						fc_d   = fc_q + CW'(1);
						rel_d  = 1'b1;
					end else begin
						ncnt_d = OUT_COUNT_WIDTH'(cnt_rd - COUNT_WIDTH'(1));
					end
				end
			end
		endcase
		stk_we = stk_we && exec_fire;
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ref_we = 1'b1;
			ref_wa = clr_q;
			ref_wd = (32'(clr_q) < 32'(RESERVED_FRAMES)) ? COUNT_WIDTH'(1) : '0;
		end else begin
			ref_we = ex_ref_we && exec_fire;
			ref_wa = ex_ref_wa;
			ref_wd = ex_ref_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q    <= '0;
			fc_q        <= CW'(INIT_FREE);
			lw_q        <= CW'(INIT_FREE);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				lowest_q <= cfg_wdata;
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + FW'(1);
			end
			if (exec_fire) begin
				fc_q        <= fc_d;
				lw_q        <= lw_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1     <= kind_t'(req.kind);
			frame_s1    <= in_frame;
			misal_s1    <= (req.page_address[PAGE_SHIFT-1:0] != '0);
			in_range_s1 <= ((FRAME_IN_WIDTH + 1)'(in_frame) < (FRAME_IN_WIDTH + 1)'(NUM_FRAMES));
			below_s1    <= (in_frame < FRAME_IN_WIDTH'(lowest_q));
			pos_s1      <= pop_pos[FW-1:0];
			pop_init_s1 <= (pop_pos < lw_q);
		end
		if (exec_fire) begin
			status_q <= st_d;
			faddr_q  <= faddr_d;
			ncnt_q   <= ncnt_d;
			rel_q    <= rel_d;
		end
	end

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("Accepted request did not move to the update stage.");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= CW'(NUM_FRAMES) && lw_q <= fc_q)
		else $error("Free stack fill level out of bounds.");

	a_release_count: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && rel_d |=> rsp.valid && rsp.status == ST_OK && rsp.new_count == '0
			&& fc_q == $past(fc_q) + CW'(1))
		else $error("Released frame response or push inconsistent.");

	a_alloc_pop: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && kind_s1 == KIND_ALLOC && st_d == ST_OK |=> fc_q == $past(fc_q) - CW'(1))
		else $error("Allocation did not pop the free stack.");

endmodule
